// ===== rtl/core/dial_digit_collector_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Dial digit collector assertion macros
// Shared concurrent assertion forms; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef DIAL_DIGIT_COLLECTOR_UNIT_DEFINES_SVH
`define DIAL_DIGIT_COLLECTOR_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define DDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dial digit collector: implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define DDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dial digit collector: next-cycle check failed");

`else

`define DDC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DDC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/ddc_pkg.sv =====
// ----------------------------------------------------------------------------
// Dial digit collector package
// Types and fixed constants shared by the collector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ddc_pkg;

   localparam int MODE_W  = 2;
   localparam int DIGIT_W = 4;
   localparam int TIMER_W = 16;

   localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd3000;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK  = 2'd0,
      MODE_HOOK  = 2'd1,
      MODE_DTMF  = 2'd2,
      MODE_OTHER = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE       = 2'd0,
      ST_WAIT_FIRST = 2'd1,
      ST_WAIT_NEXT  = 2'd2,
      ST_EMIT       = 2'd3
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic arm_timer;
      logic dec_timer;
      logic clear_all;
      logic store_digit;
      logic emit_load;
      logic emit_advance;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic timer_expiring;
      logic count_zero;
      logic last_digit;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/ddc_req_if.sv =====
// ----------------------------------------------------------------------------
// Dial digit collector request channel
// Valid/ready channel that carries one phone event per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddc_req_if;

   logic                         valid;
   logic                         ready;
   logic [ddc_pkg::MODE_W-1:0]   mode;
   logic                         hook_on;
   logic [ddc_pkg::DIGIT_W-1:0]  dtmf_code;

   modport source (output valid, output mode, output hook_on, output dtmf_code,
                   input ready);
   modport sink   (input valid, input mode, input hook_on, input dtmf_code,
                   output ready);

endinterface

`default_nettype wire

// ===== rtl/core/ddc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Dial digit collector response channel
// Valid/ready channel that carries one collected digit per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddc_rsp_if #(
   parameter int CNT_W = 5
);

   logic                         valid;
   logic                         ready;
   logic [ddc_pkg::DIGIT_W-1:0]  digit;
   logic [CNT_W-1:0]             digit_count;
   logic                         empty_number;
   logic                         last;

   modport source (output valid, output digit, output digit_count,
                   output empty_number, output last, input ready);
   modport sink   (input valid, input digit, input digit_count,
                   input empty_number, input last, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/ddc_ram.sv =====
// ----------------------------------------------------------------------------
// Dial digit collector RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ddc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Dial digit collector controller
// Call-phase state machine that sequences the datapath and both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [ddc_pkg::MODE_W-1:0]  req_mode,
   input  wire logic                        req_hook_on,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire ddc_pkg::status_type         status,
   output ddc_pkg::cmd_type                 cmd
);

   ddc_pkg::state_type state_ff;
   ddc_pkg::state_type state_in;
   ddc_pkg::mode_type  mode;
   logic               req_xfer;
   logic               rsp_xfer;
   logic               run_done;

   assign mode      = ddc_pkg::mode_type'(req_mode);
   assign req_ready = (state_ff != ddc_pkg::ST_EMIT);
   assign rsp_valid = (state_ff == ddc_pkg::ST_EMIT);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign run_done  = status.count_zero || status.last_digit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ddc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ddc_pkg::ST_IDLE: begin
            if (req_xfer && mode == ddc_pkg::MODE_HOOK && !req_hook_on) begin
               state_in = ddc_pkg::ST_WAIT_FIRST;
            end
         end
         ddc_pkg::ST_WAIT_FIRST, ddc_pkg::ST_WAIT_NEXT: begin
            if (req_xfer) begin
               unique case (mode)
                  ddc_pkg::MODE_TICK: begin
                     if (status.timer_expiring) begin
                        state_in = ddc_pkg::ST_EMIT;
                     end
                  end
                  ddc_pkg::MODE_HOOK: begin
                     if (req_hook_on) begin
                        state_in = ddc_pkg::ST_IDLE;
                     end
                  end
                  ddc_pkg::MODE_DTMF: begin
                     state_in = ddc_pkg::ST_WAIT_NEXT;
                  end
                  ddc_pkg::MODE_OTHER: begin
                     state_in = state_ff;
                  end
               endcase
            end
         end
         ddc_pkg::ST_EMIT: begin
            if (rsp_xfer && run_done) begin
               state_in = ddc_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ddc_pkg::ST_IDLE: begin
            if (req_xfer && mode == ddc_pkg::MODE_HOOK && !req_hook_on) begin
               cmd.arm_timer = 1'b1;
            end
         end
         ddc_pkg::ST_WAIT_FIRST, ddc_pkg::ST_WAIT_NEXT: begin
            if (req_xfer) begin
               unique case (mode)
                  ddc_pkg::MODE_TICK: begin
                     if (status.timer_expiring) begin
                        cmd.emit_load = 1'b1;
                     end else begin
                        cmd.dec_timer = 1'b1;
                     end
                  end
                  ddc_pkg::MODE_HOOK: begin
                     cmd.clear_all = req_hook_on;
                  end
                  ddc_pkg::MODE_DTMF: begin
                     cmd.arm_timer   = 1'b1;
                     cmd.store_digit = 1'b1;
                  end
                  ddc_pkg::MODE_OTHER: begin
                     cmd = '0;
                  end
               endcase
            end
         end
         ddc_pkg::ST_EMIT: begin
            if (rsp_xfer) begin
               if (run_done) begin
                  cmd.clear_all = 1'b1;
               end else begin
                  cmd.emit_advance = 1'b1;
               end
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/ddc_datapath.sv =====
// ----------------------------------------------------------------------------
// Dial digit collector datapath
// Timeout register, inter-digit timer, digit store and readout pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_datapath #(
   parameter int MAX_DIGITS = 16,
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
   localparam int CNT_W = $clog2(MAX_DIGITS + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [ddc_pkg::TIMER_W-1:0]   csr_wr_data,
   input  wire logic [ddc_pkg::DIGIT_W-1:0]   dtmf_code,
   input  wire ddc_pkg::cmd_type              cmd,
   output ddc_pkg::status_type                status,
   output logic      [ddc_pkg::DIGIT_W-1:0]   digit,
   output logic      [CNT_W-1:0]              digit_count,
   output logic                               empty_number,
   output logic                               last
);

   logic [ddc_pkg::TIMER_W-1:0] timeout_ff;
   logic [ddc_pkg::TIMER_W-1:0] timer_ff;
   logic [ddc_pkg::TIMER_W-1:0] timer_in;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic [IDX_W-1:0]            out_idx_ff;
   logic [IDX_W-1:0]            out_idx_in;
   logic                        store_full;
   logic                        store_wr;
   logic [ddc_pkg::DIGIT_W-1:0] rd_digit;

   assign store_full = (count_ff == CNT_W'(MAX_DIGITS));
   assign store_wr   = cmd.store_digit && !store_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ddc_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // A zero timeout arms the timer to expire on the next tick.
   always_comb begin
      timer_in = timer_ff;
      if (cmd.clear_all) begin
         timer_in = '0;
      end else if (cmd.arm_timer) begin
         timer_in = (timeout_ff == '0) ? ddc_pkg::TIMER_W'(1) : timeout_ff;
      end else if (cmd.dec_timer) begin
         timer_in = timer_ff - ddc_pkg::TIMER_W'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear_all) begin
         count_in = '0;
      end else if (store_wr) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // The read address follows the pointer's next value, so the registered
   // read data always belongs to the digit the pointer shows.
   always_comb begin
      out_idx_in = out_idx_ff;
      if (cmd.emit_load) begin
         out_idx_in = '0;
      end else if (cmd.emit_advance) begin
         out_idx_in = out_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff   <= '0;
         count_ff   <= '0;
         out_idx_ff <= '0;
      end else begin
         timer_ff   <= timer_in;
         count_ff   <= count_in;
         out_idx_ff <= out_idx_in;
      end
   end

   ddc_ram #(
      .WIDTH (ddc_pkg::DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (dtmf_code),
      .rd_addr (out_idx_in),
      .rd_data (rd_digit)
   );

   assign status.timer_expiring = (timer_ff <= ddc_pkg::TIMER_W'(1));
   assign status.count_zero     = (count_ff == '0);
   assign status.last_digit     = ((CNT_W'(out_idx_ff) + CNT_W'(1)) == count_ff);

   assign digit        = status.count_zero ? '0 : rd_digit;
   assign digit_count  = count_ff;
   assign empty_number = status.count_zero;
   assign last         = status.count_zero || status.last_digit;

endmodule

`default_nettype wire

// ===== rtl/core/dial_digit_collector_unit.sv =====
// ----------------------------------------------------------------------------
// Dial digit collector
// Collects DTMF digits after off-hook and releases them at the timeout.
// ----------------------------------------------------------------------------
// Usage:
// Phone events arrive on req_if, one per transfer: ticks, hook events, DTMF
// digits and ignored events. While the block is idle or collecting, every
// event is taken at once and causes no result except the expiring tick.
// When the timer expires, req_if.ready drops and the collected digits leave on
// rsp_if in dialing order, one transfer per cycle while the receiver is ready,
// the first one in the cycle after the expiring tick. The last transfer has
// last set; with nothing dialed a single empty result goes out instead.
// A run of digits thus holds the request side until its last digit is taken, as
// the digit store has one read port. A stalled receiver simply holds the current
// digit and the request side stays blocked until the run is done.
// The timeout register on the csr port takes effect at the next arming of the
// timer. Reset returns the block to idle with the timeout at 3000 ticks;
// the digit store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dial_digit_collector_unit_defines.svh"

module dial_digit_collector_unit #(
   parameter int MAX_DIGITS = 16,
   localparam int CNT_W = $clog2(MAX_DIGITS + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   ddc_req_if.sink                           req_if,
   ddc_rsp_if.source                         rsp_if,
   input  wire logic                         csr_wr_en,
   input  wire logic [ddc_pkg::TIMER_W-1:0]  csr_wr_data
);

   ddc_pkg::cmd_type    cmd;
   ddc_pkg::status_type status;

   // The controller owns both handshakes; the datapath owns all storage.
   ddc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_mode    (req_if.mode),
      .req_hook_on (req_if.hook_on),
      .req_ready   (req_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .status      (status),
      .cmd         (cmd)
   );

   ddc_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .dtmf_code    (req_if.dtmf_code),
      .cmd          (cmd),
      .status       (status),
      .digit        (rsp_if.digit),
      .digit_count  (rsp_if.digit_count),
      .empty_number (rsp_if.empty_number),
      .last         (rsp_if.last)
   );

   // No event is taken while a run of digits is going out.
   `DDC_ASSERT_IMPLY(a_no_req_during_run, clock, reset, rsp_if.valid, !req_if.ready)

   // The reported count never exceeds the store capacity.
   `DDC_ASSERT_IMPLY(a_count_bound, clock, reset, rsp_if.valid,
                     rsp_if.digit_count <= CNT_W'(MAX_DIGITS))

   // An empty number is always a run of one.
   `DDC_ASSERT_IMPLY(a_empty_is_last, clock, reset,
                     rsp_if.valid && rsp_if.empty_number, rsp_if.last)

   // The run ends right after its last transfer.
   `DDC_ASSERT_NEXT(a_run_ends, clock, reset,
                    rsp_if.valid && rsp_if.ready && rsp_if.last, !rsp_if.valid)

endmodule

`default_nettype wire

// ===== tb/sv/dial_digit_collector_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Dial digit collector testbench
// Drives phone events into the collector and checks every emitted digit
// against a cycle-free predictor of the dialing state kept in a scoreboard.
// ----------------------------------------------------------------------------

// One emitted result as it appears on the response channel.
typedef struct packed {
   logic [3:0] digit;
   logic [4:0] digit_count;
   logic       empty_number;
   logic       last;
} dialed_digit_type;

class dialed_number_board #(int MAX_DIGITS = 16);

   bit [15:0]          timeout_ticks;
   ddc_pkg::state_type line_state;
   bit [15:0]          ticks_left;
   logic [3:0]         digit_store [MAX_DIGITS];
   int unsigned        stored;
   dialed_digit_type   expected_digits [$];
   int unsigned        mismatches;
   int unsigned        results_seen;
   int unsigned        empty_numbers;
   int unsigned        dropped_digits;

   function new();
      timeout_ticks = ddc_pkg::TIMEOUT_RESET;
      line_state    = ddc_pkg::ST_IDLE;
      ticks_left    = '0;
      stored        = 0;
   endfunction

   function void write_timeout(bit [15:0] value);
      timeout_ticks = value;
   endfunction

   function void restart_timer();
      ticks_left = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
   endfunction

   function void hang_up();
      line_state = ddc_pkg::ST_IDLE;
      ticks_left = '0;
      stored     = 0;
   endfunction

   // Timer expired: queue the collected number, or one empty result.
   function void release_number();
      dialed_digit_type entry;
      if (stored == 0) begin
         entry.digit        = 4'd0;
         entry.digit_count  = 5'd0;
         entry.empty_number = 1'b1;
         entry.last         = 1'b1;
         expected_digits.push_back(entry);
         empty_numbers++;
      end else begin
         for (int i = 0; i < stored; i++) begin
            entry.digit        = digit_store[i];
            entry.digit_count  = 5'(stored);
            entry.empty_number = 1'b0;
            entry.last         = (i == stored - 1);
            expected_digits.push_back(entry);
         end
      end
      hang_up();
   endfunction

   // Returns 1 when the event changed the dialing state.
   function bit note_request(ddc_pkg::mode_type kind, logic hook, logic [3:0] code);
      bit acted;
      acted = 1'b0;
      if (line_state == ddc_pkg::ST_IDLE) begin
         if (kind == ddc_pkg::MODE_HOOK && !hook) begin
            line_state = ddc_pkg::ST_WAIT_FIRST;
            restart_timer();
            acted = 1'b1;
         end
      end else begin
         case (kind)
            ddc_pkg::MODE_TICK: begin
               if (ticks_left > 16'd1) ticks_left--;
               else release_number();
               acted = 1'b1;
            end
            ddc_pkg::MODE_HOOK: begin
               if (hook) begin
                  hang_up();
                  acted = 1'b1;
               end
            end
            ddc_pkg::MODE_DTMF: begin
               restart_timer();
               line_state = ddc_pkg::ST_WAIT_NEXT;
               if (stored < MAX_DIGITS) begin
                  digit_store[stored] = code;
                  stored++;
               end else begin
                  dropped_digits++;
               end
               acted = 1'b1;
            end
            default: ;
         endcase
      end
      return acted;
   endfunction

   function void check_result(dialed_digit_type got);
      dialed_digit_type want;
      results_seen++;
      if (expected_digits.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t ERROR: result with none expected: digit=%0d count=%0d empty=%0b last=%0b",
                     $time, got.digit, got.digit_count, got.empty_number, got.last);
         return;
      end
      want = expected_digits.pop_front();
      if (got.digit !== want.digit || got.digit_count !== want.digit_count ||
          got.empty_number !== want.empty_number || got.last !== want.last) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t ERROR: result %0d: expected digit=%0d count=%0d empty=%0b last=%0b,",
                     $time, results_seen, want.digit, want.digit_count, want.empty_number,
                     want.last);
            $display("   got digit=%0d count=%0d empty=%0b last=%0b",
                     got.digit, got.digit_count, got.empty_number, got.last);
         end
      end
   endfunction

   function int pending();
      return expected_digits.size();
   endfunction

endclass

module dial_digit_collector_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIGITS   = 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   // Idle cycles allowed after the last result before the block counts as quiet.
   localparam int LATENCY_PAD  = 8;
   localparam int RANDOM_ITEMS = 430;
   localparam int PHASES       = 8;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_wr_en;
   logic [ddc_pkg::TIMER_W-1:0] csr_wr_data;

   ddc_req_if              req_if ();
   ddc_rsp_if #(.CNT_W(5)) rsp_if ();

   dialed_number_board #(MAX_DIGITS) number_board;

   // Idling percentages for the current phase; the sender idles before a
   // transfer, the receiver drops ready on a cycle by cycle basis.
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   bit [15:0]   cur_timeout;
   int unsigned acting_items  = 0;
   int unsigned sent_items    = 0;
   int unsigned cycle_count   = 0;
   int unsigned phase_timeouts [PHASES] = '{1, 4, 0, 6, 2, 5, 3, 1};

   dial_digit_collector_unit #(
      .MAX_DIGITS (MAX_DIGITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // The receiver decides its ready for the next edge at every falling edge,
   // so stalls can land on any cycle of a digit run.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Every response transfer is checked against the oldest expected digit.
   always @(posedge clock) begin
      dialed_digit_type got;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.digit        = rsp_if.digit;
         got.digit_count  = rsp_if.digit_count;
         got.empty_number = rsp_if.empty_number;
         got.last         = rsp_if.last;
         number_board.check_result(got);
      end
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, number_board.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Presents one phone event and holds it until the block takes it. The
   // fields change only at the falling edge, and the transfer is recognized
   // at the rising edge, where ready still shows its value from before the edge.
   task automatic send_request(input ddc_pkg::mode_type kind, input logic hook,
                               input logic [3:0] code);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.mode      <= kind;
      req_if.hook_on   <= hook;
      req_if.dtmf_code <= code;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      if (number_board.note_request(kind, hook, code)) acting_items++;
      sent_items++;
   endtask

   // Brings the block to rest: no request offered, every expected digit
   // delivered, then a short pause for events that cause no result.
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (number_board.pending() != 0) @(posedge clock);
      repeat (LATENCY_PAD) @(posedge clock);
   endtask

   // The predictor takes the new timeout at the same edge as the block.
   task automatic write_timeout(input bit [15:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      number_board.write_timeout(value);
      cur_timeout = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_noise();
      send_request(ddc_pkg::mode_type'($urandom_range(3)), 1'($urandom_range(1)),
                   4'($urandom_range(15)));
   endtask

   // One call: off-hook, a number of digits with ticks between them that stay
   // below the timeout, then enough ticks to expire. Some calls dial past the
   // store size, a few are hung up early, and stray events are mixed in.
   task automatic place_call();
      int unsigned span;
      int unsigned digits;
      int          hang_at;
      span    = (cur_timeout == 16'd0) ? 1 : cur_timeout;
      digits  = ($urandom_range(4) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
      hang_at = ($urandom_range(9) == 0) ? int'($urandom_range(digits)) : -1;
      send_request(ddc_pkg::MODE_HOOK, 1'b0, 4'($urandom_range(15)));
      for (int d = 0; d <= digits; d++) begin
         if (d == hang_at) begin
            send_request(ddc_pkg::MODE_HOOK, 1'b1, 4'($urandom_range(15)));
            return;
         end
         if (d == digits) break;
         repeat ($urandom_range(span - 1))
            send_request(ddc_pkg::MODE_TICK, 1'($urandom_range(1)), 4'($urandom_range(15)));
         case ($urandom_range(15))
            0: send_request(ddc_pkg::MODE_OTHER, 1'($urandom_range(1)),
                            4'($urandom_range(15)));
            1: send_request(ddc_pkg::MODE_HOOK, 1'b0, 4'($urandom_range(15)));
            default: ;
         endcase
         send_request(ddc_pkg::MODE_DTMF, 1'($urandom_range(1)), 4'($urandom_range(15)));
      end
      repeat (span)
         send_request(ddc_pkg::MODE_TICK, 1'($urandom_range(1)), 4'($urandom_range(15)));
      // Now and then a tick that finds the line idle again.
      if ($urandom_range(3) == 0)
         send_request(ddc_pkg::MODE_TICK, 1'($urandom_range(1)), 4'($urandom_range(15)));
   endtask

   initial begin
      int unsigned base_items;

      number_board     = new();
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.mode      = ddc_pkg::MODE_TICK;
      req_if.hook_on   = 1'b0;
      req_if.dtmf_code = 4'd0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      cur_timeout      = ddc_pkg::TIMEOUT_RESET;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, first with the timeout left at its reset value.
      // Events that an idle line must ignore.
      send_request(ddc_pkg::MODE_OTHER, 1'b1, 4'd15);
      send_request(ddc_pkg::MODE_TICK, 1'b0, 4'd0);
      send_request(ddc_pkg::MODE_DTMF, 1'b0, 4'd9);
      send_request(ddc_pkg::MODE_HOOK, 1'b1, 4'd0);
      // Off-hook arms the timer; a second off-hook and a mode 3 event do nothing,
      // a digit is stored, a tick counts down and on-hook throws it all away.
      send_request(ddc_pkg::MODE_HOOK, 1'b0, 4'd0);
      send_request(ddc_pkg::MODE_HOOK, 1'b0, 4'd3);
      send_request(ddc_pkg::MODE_DTMF, 1'b1, 4'd15);
      send_request(ddc_pkg::MODE_OTHER, 1'b0, 4'd0);
      send_request(ddc_pkg::MODE_TICK, 1'b1, 4'd5);
      send_request(ddc_pkg::MODE_HOOK, 1'b1, 4'd0);

      // A zero timeout acts as one tick, so the first tick gives an empty number.
      settle();
      write_timeout(16'd0);
      send_request(ddc_pkg::MODE_HOOK, 1'b0, 4'd0);
      send_request(ddc_pkg::MODE_TICK, 1'b0, 4'd0);

      // Longest timeout, then a shorter one written while that count runs:
      // the running count keeps going and only the next digit picks up the
      // new value, after which two ticks release the number.
      settle();
      write_timeout(16'hFFFF);
      send_request(ddc_pkg::MODE_HOOK, 1'b0, 4'd0);
      send_request(ddc_pkg::MODE_DTMF, 1'b0, 4'd0);
      send_request(ddc_pkg::MODE_TICK, 1'b0, 4'd0);
      settle();
      write_timeout(16'd2);
      send_request(ddc_pkg::MODE_TICK, 1'b0, 4'd0);
      send_request(ddc_pkg::MODE_DTMF, 1'b0, 4'd7);
      send_request(ddc_pkg::MODE_TICK, 1'b0, 4'd0);
      send_request(ddc_pkg::MODE_TICK, 1'b0, 4'd0);

      // Random part in phases of differing timeout and idling: none, sender
      // idle most of the time, receiver stalled most of the time, both lightly.
      base_items = sent_items;
      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 80; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 80; end
            default: begin send_idle_pct = 23; rsp_stall_pct = 23; end
         endcase
         write_timeout(16'(phase_timeouts[p]));
         while (sent_items < base_items + (p + 1) * RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(9) < 8) place_call();
            else send_noise();
         end
      end

      settle();

      $display("Sent %0d phone events, %0d of which changed the line state.",
               sent_items, acting_items);
      $display("Checked %0d digits, %0d empty numbers and %0d digits dropped on overflow.",
               number_board.results_seen, number_board.empty_numbers,
               number_board.dropped_digits);
      if (number_board.mismatches == 0 && number_board.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches seen.", number_board.mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
